>>> sv/tsca_pkg.sv
// tsca_pkg: shared constants and types of the two-stage current averager
// no dependencies; used by tsca_div and two_stage_current_averager
package tsca_pkg;

    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 19;
    localparam logic [THRESH_W-1:0] THRESH_RST = 19'd20;

    // status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> sv/tsca_div.sv
// tsca_div: serial signed-by-unsigned divider, one quotient bit per cycle
// truncates toward zero; depends on tsca_pkg
module tsca_div #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic        [DVS_W-1:0] i_divisor,
    output tsca_pkg::t_div_sts      o_sts,
    output logic signed [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic             r_neg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVD_W-1:0] mag;

    assign mag     = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: restoring division on the magnitude
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_neg <= i_dividend[DVD_W-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

>>> sv/two_stage_current_averager.sv
// two_stage_current_averager: block sums of current samples, ring of block sums,
// long average by a serial divider; depends on tsca_pkg and tsca_div
//
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_stall     i_current_sample
// out      output     o_out_valid / i_out_stall   o_average_current, o_window_full
// cfg      input      i_cfg_wr_en                 i_cfg_wr_data (quiet threshold)
//
// an item that does not close a block passes the calc, wait and finish states; one that closes
// a block first passes the read and update states for the ring read and update
// the wait state is set by the serial divider, one quotient bit per cycle over TOT_W bits;
// with an empty window the divider is skipped and the calc state goes straight to finish
// one item at a time; o_in_stall is high from acceptance until the result is loaded
// into the output register, which holds it while i_out_stall is high
// synchronous active-low reset clears control state and the threshold to 20;
// the ring of block sums is not cleared, its read value is only used once fully written
module two_stage_current_averager #(
    parameter int BLOCK_LEN     = 10,
    parameter int WINDOW_BLOCKS = 60
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [tsca_pkg::SAMPLE_W-1:0] i_current_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [tsca_pkg::SAMPLE_W-1:0] o_average_current,
    output logic                                 o_window_full,
    input  logic                                 i_cfg_wr_en,
    input  logic        [tsca_pkg::THRESH_W-1:0] i_cfg_wr_data
);

    // widths of the block sum, the window total, the counters, the divisor and the compare
    localparam int BLK_W  = tsca_pkg::SAMPLE_W + $clog2(BLOCK_LEN);
    localparam int TOT_W  = BLK_W + $clog2(WINDOW_BLOCKS);
    localparam int CNT_W  = $clog2(BLOCK_LEN);
    localparam int BS_W   = $clog2(2 * WINDOW_BLOCKS + 1);
    localparam int SLOT_W = $clog2(WINDOW_BLOCKS);
    localparam int DVS_W  = $clog2(WINDOW_BLOCKS * BLOCK_LEN + 1);
    localparam int CMP_W  = (BLK_W > tsca_pkg::THRESH_W) ? BLK_W : tsca_pkg::THRESH_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_CALC = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]                        r_state;
    logic [tsca_pkg::THRESH_W-1:0]     r_thresh;
    logic signed [BLK_W-1:0]           r_acc;
    logic [CNT_W-1:0]                  r_cnt;
    logic signed [BLK_W-1:0]           r_sum;
    logic signed [BLK_W-1:0]           r_rd;
    logic [BS_W-1:0]                   r_bs;
    logic signed [TOT_W-1:0]           r_total;
    logic signed [tsca_pkg::SAMPLE_W-1:0] r_res;
    logic                              r_res_full;
    logic                              r_ovalid;
    logic signed [tsca_pkg::SAMPLE_W-1:0] r_oavg;
    logic                              r_ofull;

    // ring of block sums
    logic signed [BLK_W-1:0] mem [WINDOW_BLOCKS];

    logic                    in_acc;
    logic                    out_free;
    logic                    full;
    logic [SLOT_W-1:0]       slot;
    logic signed [BLK_W-1:0] n_acc;
    logic [BS_W-1:0]         n_bs;
    logic [BLK_W-1:0]        sum_mag;
    logic                    quiet;
    logic [DVS_W-1:0]        divisor;
    logic                    div_start;
    tsca_pkg::t_div_sts      div_sts;
    logic signed [TOT_W-1:0] div_quo;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign full     = r_bs >= BS_W'(WINDOW_BLOCKS);
    assign slot     = full ? SLOT_W'(r_bs - BS_W'(WINDOW_BLOCKS)) : SLOT_W'(r_bs);
    assign n_acc    = r_acc + BLK_W'(i_current_sample);

    // next ring position, wrapping inside full mode
    always_comb begin
        n_bs = r_bs + 1'b1;
        if (n_bs >= BS_W'(2 * WINDOW_BLOCKS)) begin
            n_bs = BS_W'(WINDOW_BLOCKS);
        end
    end

    assign sum_mag = r_sum[BLK_W-1] ? BLK_W'(-r_sum) : BLK_W'(r_sum);
    assign quiet   = CMP_W'(sum_mag) < CMP_W'(r_thresh);

    // number of samples behind the window total
    assign divisor = full ? DVS_W'(WINDOW_BLOCKS * BLOCK_LEN)
                          : DVS_W'(r_bs) * DVS_W'(BLOCK_LEN);
    assign div_start = (r_state == ST_CALC) && (r_bs != '0);

    tsca_div #(
        .DVD_W (TOT_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_total),
        .i_divisor  (divisor),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= tsca_pkg::THRESH_RST;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    // ring memory, registered read of the slot about to be replaced
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd <= mem[slot];
        end
        if (r_state == ST_UPD) begin
            mem[slot] <= r_sum;
        end
    end

    // sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_bs     <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // output register: loaded from the finish state, emptied when taken
            if (r_state == ST_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (r_cnt == CNT_W'(BLOCK_LEN - 1)) begin
                            // block closes: hand the sum to the ring
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_READ;
                        end else begin
                            r_acc   <= n_acc;
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= ST_CALC;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (quiet) begin
                        // quiet block restarts the long window
                        r_bs    <= '0;
                        r_total <= '0;
                    end else begin
                        r_bs    <= n_bs;
                        r_total <= full ? r_total - TOT_W'(r_rd) + TOT_W'(r_sum)
                                        : r_total + TOT_W'(r_sum);
                    end
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    if (r_bs == '0) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (div_sts.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_sum <= n_acc;
        end
        if (r_state == ST_CALC) begin
            r_res      <= '0;
            r_res_full <= full;
        end
        if (r_state == ST_WAIT && div_sts.done) begin
            r_res <= div_quo[tsca_pkg::SAMPLE_W-1:0];
        end
        if (r_state == ST_FIN && out_free) begin
            r_oavg  <= r_res;
            r_ofull <= r_res_full;
        end
    end

    assign o_in_stall        = r_state != ST_IDLE;
    assign o_out_valid       = r_ovalid;
    assign o_average_current = r_oavg;
    assign o_window_full     = r_ofull;

    // ring position never leaves its two ranges
    a_bs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bs < BS_W'(2 * WINDOW_BLOCKS))
        else $error("ring position out of range");

    // samples in the open block stay below the block length
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(BLOCK_LEN - 1) || r_cnt == CNT_W'(BLOCK_LEN - 1))
        else $error("block sample count out of range");

    // the divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> r_state == ST_WAIT)
        else $error("divider result outside wait state");

    // an accepted item always leads to a busy sequencer next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("sequencer did not start on accepted item");

    // a full-window result never comes from an empty window
    a_full_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && r_bs == '0) |=> !r_res_full)
        else $error("empty window flagged full");

endmodule
